// ----- rtl/integer_key_hash_table_unit_macros.svh -----
// Assertion helpers shared by the hash table modules
`ifndef INTEGER_KEY_HASH_TABLE_UNIT_MACROS_SVH
`define INTEGER_KEY_HASH_TABLE_UNIT_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define IKHT_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("hash table check failed");

// Consequence must hold in the cycle after the antecedent
`define IKHT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hash table sequence check failed");

`endif

// ----- rtl/ikht_pkg.sv -----
`default_nettype none
package ikht_pkg;

    // Operation codes
    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_GET    = 2'd1,
        FN_REMOVE = 2'd2,
        FN_CLEAR  = 2'd3
    } func_t;

    // Result status codes
    localparam logic [2:0] ST_NEW    = 3'd0;
    localparam logic [2:0] ST_HIT    = 3'd1;
    localparam logic [2:0] ST_MISS   = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_BADKEY = 3'd4;

    // Controller states, one-hot
    typedef enum logic [7:0] {
        S_INIT  = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_SWEEP = 8'b0000_0100,
        S_HEAD  = 8'b0000_1000,
        S_LOAD  = 8'b0001_0000,
        S_READ  = 8'b0010_0000,
        S_CMP   = 8'b0100_0000,
        S_ACT   = 8'b1000_0000
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // latch the request
        logic sweep;       // write one bucket head to empty
        logic clear_done;  // finish a clear and emit its result
        logic load_head;   // start a chain walk at the bucket head
        logic step;        // follow the chain link
        logic mark_hit;    // key found at current entry
        logic act;         // apply the operation and emit the result
        logic reject;      // emit the invalid key result
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic in_clear;
        logic in_key_zero;
        logic head_empty;
        logic key_match;
        logic next_empty;
        logic sweep_last;
    } sts_t;

endpackage
`default_nettype wire

// ----- rtl/ikht_ctrl.sv -----
`default_nettype none
module ikht_ctrl
    import ikht_pkg::*;
(
    input  wire  logic clk,
    input  wire  logic rst_n,
    input  wire  logic start,
    output logic       busy,
    input  wire  sts_t sts,
    output cmd_t       cmd
);

`include "integer_key_hash_table_unit_macros.svh"

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (sts.in_clear)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_SWEEP;
                    end
                    else if (sts.in_key_zero)
                    begin
                        cmd.reject = 1'b1;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_HEAD;
                    end
                end
            end
            S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    cmd.clear_done = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_HEAD:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load_head = 1'b1;
                state_next    = sts.head_empty ? S_ACT : S_READ;
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (sts.key_match)
                begin
                    cmd.mark_hit = 1'b1;
                    state_next   = S_ACT;
                end
                else if (sts.next_empty)
                begin
                    state_next = S_ACT;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_ACT:
            begin
                cmd.act    = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // Checks
    `IKHT_ASSERT_NEXT(a_act_ends, clk, rst_n, state_reg == S_ACT, state_reg == S_IDLE)
    `IKHT_ASSERT_NEXT(a_walk_on, clk, rst_n,
        state_reg == S_CMP && !sts.key_match && !sts.next_empty, state_reg == S_READ)
    `IKHT_ASSERT_NEXT(a_sweep_end, clk, rst_n,
        state_reg == S_SWEEP && sts.sweep_last, state_reg == S_IDLE)

endmodule
`default_nettype wire

// ----- rtl/ikht_dp.sv -----
`default_nettype none
module ikht_dp
    import ikht_pkg::*;
#(
    parameter int BUCKETS = 16,
    parameter int ENTRIES = 64
)
(
    input  wire  logic                           clk,
    input  wire  logic                           rst_n,
    input  wire  logic [1:0]                     func,
    input  wire  logic [63:0]                    key,
    input  wire  logic [63:0]                    value,
    input  wire  cmd_t                           cmd,
    output sts_t                                 sts,
    output logic                                 done,
    output logic [2:0]                           status,
    output logic [63:0]                          value_out,
    output logic [$clog2(ENTRIES+1)-1:0]         entry_count
);

`include "integer_key_hash_table_unit_macros.svh"

    localparam int IW = $clog2(ENTRIES);
    localparam int XW = $clog2(ENTRIES + 1);
    localparam int BW = $clog2(BUCKETS);
    localparam logic [XW-1:0] EMPTY = XW'(ENTRIES);
    localparam logic [BW-1:0] BMASK = BW'(BUCKETS - 1);

    // Memories
    logic [XW-1:0] head_mem [BUCKETS];
    logic [63:0]   key_mem  [ENTRIES];
    logic [63:0]   val_mem  [ENTRIES];
    logic [XW-1:0] next_mem [ENTRIES];
    logic [IW-1:0] free_mem [ENTRIES];

    // Request and walk registers
    logic [1:0]    func_reg;
    logic [63:0]   key_reg;
    logic [63:0]   value_reg;
    logic [XW-1:0] cur_reg, cur_next;
    logic [XW-1:0] prev_reg, prev_next;

    // Registered memory reads
    logic [XW-1:0] head_rd_reg;
    logic [63:0]   key_rd_reg;
    logic [63:0]   val_rd_reg;
    logic [XW-1:0] next_rd_reg;
    logic [IW-1:0] free_rd_reg;

    // Control state
    logic [XW-1:0] count_reg, count_next;
    logic [XW-1:0] sp_reg, sp_next;
    logic [XW-1:0] fill_reg, fill_next;
    logic          found_reg, found_next;
    logic [BW-1:0] sweep_cnt_reg, sweep_cnt_next;
    logic          done_reg, done_next;

    // Result registers
    logic [2:0]    status_reg, status_next;
    logic [63:0]   value_out_reg, value_out_next;

    // Memory write controls
    logic          head_we;
    logic [BW-1:0] head_wa;
    logic [XW-1:0] head_wd;
    logic          ent_we;
    logic [IW-1:0] ent_wa;
    logic          val_we;
    logic [IW-1:0] val_wa;
    logic          next_we;
    logic [IW-1:0] next_wa;
    logic [XW-1:0] next_wd;
    logic          free_we;

    logic [BW-1:0] bkt;
    logic [IW-1:0] cur_idx;
    logic [IW-1:0] sp_top;
    logic [IW-1:0] slot;

    assign bkt     = key_reg[BW-1:0] & BMASK;
    assign cur_idx = cur_reg[IW-1:0];
    assign sp_top  = IW'(sp_reg - XW'(1));
    assign slot    = (sp_reg != '0) ? free_rd_reg : fill_reg[IW-1:0];

    // Status to controller
    always_comb
    begin
        sts.in_clear    = (func == FN_CLEAR);
        sts.in_key_zero = (key == 64'd0);
        sts.head_empty  = (head_rd_reg == EMPTY);
        sts.key_match   = (key_rd_reg == key_reg);
        sts.next_empty  = (next_rd_reg == EMPTY);
        sts.sweep_last  = (sweep_cnt_reg == BW'(BUCKETS - 1));
    end

    // Operation logic
    always_comb
    begin
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        count_next     = count_reg;
        sp_next        = sp_reg;
        fill_next      = fill_reg;
        found_next     = found_reg;
        sweep_cnt_next = sweep_cnt_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        value_out_next = value_out_reg;
        head_we        = 1'b0;
        head_wa        = bkt;
        head_wd        = EMPTY;
        ent_we         = 1'b0;
        ent_wa         = slot;
        val_we         = 1'b0;
        val_wa         = slot;
        next_we        = 1'b0;
        next_wa        = slot;
        next_wd        = head_rd_reg;
        free_we        = 1'b0;

        if (cmd.load)
        begin
            found_next = 1'b0;
        end
        if (cmd.sweep)
        begin
            head_we        = 1'b1;
            head_wa        = sweep_cnt_reg;
            head_wd        = EMPTY;
            sweep_cnt_next = sweep_cnt_reg + BW'(1);
        end
        if (cmd.clear_done)
        begin
            count_next     = '0;
            sp_next        = '0;
            fill_next      = '0;
            done_next      = 1'b1;
            status_next    = ST_HIT;
            value_out_next = 64'd0;
        end
        if (cmd.reject)
        begin
            done_next      = 1'b1;
            status_next    = ST_BADKEY;
            value_out_next = 64'd0;
        end
        if (cmd.load_head)
        begin
            cur_next  = head_rd_reg;
            prev_next = EMPTY;
        end
        if (cmd.step)
        begin
            cur_next  = next_rd_reg;
            prev_next = cur_reg;
        end
        if (cmd.mark_hit)
        begin
            found_next = 1'b1;
        end
        if (cmd.act)
        begin
            done_next      = 1'b1;
            value_out_next = 64'd0;
            if (func_reg == FN_INSERT)
            begin
                if (found_reg)
                begin
                    // replace value in place
                    val_we         = 1'b1;
                    val_wa         = cur_idx;
                    status_next    = ST_HIT;
                    value_out_next = val_rd_reg;
                end
                else if (count_reg == EMPTY)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    // new entry goes to the chain head
                    ent_we      = 1'b1;
                    val_we      = 1'b1;
                    next_we     = 1'b1;
                    next_wd     = head_rd_reg;
                    head_we     = 1'b1;
                    head_wd     = XW'(slot);
                    count_next  = count_reg + XW'(1);
                    status_next = ST_NEW;
                    if (sp_reg != '0)
                    begin
                        sp_next = sp_reg - XW'(1);
                    end
                    else
                    begin
                        fill_next = fill_reg + XW'(1);
                    end
                end
            end
            else if (!found_reg)
            begin
                status_next = ST_MISS;
            end
            else if (func_reg == FN_GET)
            begin
                status_next    = ST_HIT;
                value_out_next = val_rd_reg;
            end
            else
            begin
                // unlink and free the slot
                status_next    = ST_HIT;
                value_out_next = val_rd_reg;
                if (prev_reg == EMPTY)
                begin
                    head_we = 1'b1;
                    head_wd = next_rd_reg;
                end
                else
                begin
                    next_we = 1'b1;
                    next_wa = prev_reg[IW-1:0];
                    next_wd = next_rd_reg;
                end
                free_we    = 1'b1;
                sp_next    = sp_reg + XW'(1);
                count_next = count_reg - XW'(1);
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sp_reg        <= '0;
            fill_reg      <= '0;
            found_reg     <= 1'b0;
            sweep_cnt_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            sp_reg        <= sp_next;
            fill_reg      <= fill_next;
            found_reg     <= found_next;
            sweep_cnt_reg <= sweep_cnt_next;
            done_reg      <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func;
            key_reg   <= key;
            value_reg <= value;
        end
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        status_reg    <= status_next;
        value_out_reg <= value_out_next;
    end

    // Bucket head memory
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_wa] <= head_wd;
        end
        head_rd_reg <= head_mem[bkt];
    end

    // Entry memories
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            key_mem[ent_wa] <= key_reg;
        end
        key_rd_reg <= key_mem[cur_idx];
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_wa] <= value_reg;
        end
        val_rd_reg <= val_mem[cur_idx];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        next_rd_reg <= next_mem[cur_idx];
    end

    // Free slot stack
    always_ff @(posedge clk)
    begin
        if (free_we)
        begin
            free_mem[sp_reg[IW-1:0]] <= cur_idx;
        end
        free_rd_reg <= free_mem[sp_top];
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign value_out   = value_out_reg;
    assign entry_count = count_reg;

    // Checks
    `IKHT_ASSERT(a_pool_sum, clk, rst_n, fill_reg == count_reg + sp_reg)
    `IKHT_ASSERT(a_count_max, clk, rst_n, count_reg <= EMPTY)
    `IKHT_ASSERT(a_new_counts, clk, rst_n,
        !(done_reg && status_reg == ST_NEW) || count_reg == $past(count_reg) + XW'(1))

endmodule
`default_nettype wire

// ----- rtl/integer_key_hash_table_unit.sv -----
// Channel   Transfer when        Signals
// request   start && !busy       func, key, value
// result    done (one cycle)     status, value_out, entry_count
//
// Get, remove and insert read the bucket head, then walk the chain until the
// key is found or the chain ends; an empty bucket skips the walk.
// For each entry the chain walk does a registered entry memory read, then
// the key compare. Invalid keys are answered from idle without a walk.
// Clear sweeps the bucket head memory; after reset the same sweep runs with
// busy high.
// The result strobe cannot be stalled; busy drops in the cycle of done.
`default_nettype none
module integer_key_hash_table_unit
    import ikht_pkg::*;
#(
    parameter int BUCKETS = 16,
    parameter int ENTRIES = 64
)
(
    input  wire  logic                           clk,
    input  wire  logic                           rst_n,
    input  wire  logic                           start,
    output logic                                 busy,
    input  wire  logic [1:0]                     func,
    input  wire  logic [63:0]                    key,
    input  wire  logic [63:0]                    value,
    output logic                                 done,
    output logic [2:0]                           status,
    output logic [63:0]                          value_out,
    output logic [$clog2(ENTRIES+1)-1:0]         entry_count
);

    cmd_t cmd;
    sts_t sts;

    ikht_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    ikht_dp #(
        .BUCKETS (BUCKETS),
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .func        (func),
        .key         (key),
        .value       (value),
        .cmd         (cmd),
        .sts         (sts),
        .done        (done),
        .status      (status),
        .value_out   (value_out),
        .entry_count (entry_count)
    );

endmodule
`default_nettype wire
